// File: hw/rtl/adn_pkg.sv
`default_nettype none

package adn_pkg;

	localparam int BLOCK_DEPTH = 64;
	localparam int ADDR_W      = $clog2(BLOCK_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int FRAC_BITS   = 14;
	localparam int MAG_W       = FRAC_BITS + 1;
	localparam int ENTRY_W     = MAG_W + 1;
	localparam int ABS_W       = 8;
	localparam int SX_W        = 14;
	localparam int SY_W        = 22;
	localparam int PROD_W      = SX_W + MAG_W;
	localparam int QUO_W       = 7;
	localparam int DIV_W       = SY_W + QUO_W - 1;
	localparam int DIV_CNT_W   = 3;
	localparam int ROM_DEPTH   = 129;

	localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;
	localparam logic [63:0] DRIVE_NUM   = 64'd4001;
	localparam logic [63:0] DRIVE_DEN   = 64'd1280;

	typedef logic [MAG_W-1:0] mag_rom_t [0:ROM_DEPTH-1];

	typedef struct packed {
		logic              wr;
		logic              clr;
		logic              rd;
		logic              mul;
		logic              sat;
		logic              div;
		logic [ADDR_W-1:0] rd_addr;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
	} status_t;

	// shift-subtract quotient, evaluated only while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] r;
		begin
			q = '0;
			r = '0;
			for (int i = 63; i >= 0; i--) begin
				r = {r[62:0], num[i]};
				if (r >= den) begin
					r    = r - den;
					q[i] = 1'b1;
				end
			end
			return q;
		end
	endfunction

	// pi/2 - atan(1/a) by an alternating series in Q32, rounded to the table format
	function automatic logic [MAG_W-1:0] atan_mag(input int m);
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] p;
		logic [63:0] s;
		logic [63:0] v;
		logic [63:0] term;
		logic        sub;
		int          n;
		begin
			u   = udiv64(DRIVE_DEN << 32, DRIVE_NUM * 64'(m));
			u2  = (u * u) >> 32;
			s   = u;
			p   = u;
			sub = 1'b1;
			for (n = 3; (p != 64'd0) && (n < 400); n += 2) begin
				p    = (p * u2) >> 32;
				term = udiv64(p, 64'(n));
				if (sub) begin
					s = s - term;
				end else begin
					s = s + term;
				end
				sub = !sub;
			end
			v = HALF_PI_Q32 - s;
			v = (v + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
			return v[MAG_W-1:0];
		end
	endfunction

	function automatic mag_rom_t build_mag_rom();
		mag_rom_t rom;
		begin
			rom[0] = '0;
			for (int m = 1; m < ROM_DEPTH; m++) begin
				rom[m] = atan_mag(m);
			end
			return rom;
		end
	endfunction

	localparam mag_rom_t MAG_ROM = build_mag_rom();

endpackage

`default_nettype wire

// File: hw/rtl/adn_datapath.sv
`default_nettype none

module adn_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire adn_pkg::cmd_t   cmd,
	output adn_pkg::status_t     status,
	input  wire logic [7:0]      sample,
	output logic [7:0]           sample_out
);

	logic [adn_pkg::ENTRY_W-1:0] store_q [0:adn_pkg::BLOCK_DEPTH-1];
	logic [adn_pkg::ENTRY_W-1:0] rd_q;
	logic [adn_pkg::CNT_W-1:0]   cnt_q;
	logic [adn_pkg::SX_W-1:0]    sx_q;
	logic [adn_pkg::SY_W-1:0]    sy_q;
	logic [adn_pkg::PROD_W-1:0]  prod_q;
	logic                        neg_q;
	logic [adn_pkg::PROD_W-1:0]  rem_q;
	logic [adn_pkg::DIV_W-1:0]   dv_q;
	logic [adn_pkg::QUO_W-1:0]   quo_q;
	logic                        sat_q;
	logic                        zero_q;

	logic                        in_neg;
	logic [adn_pkg::ABS_W-1:0]   in_abs;
	logic [adn_pkg::MAG_W-1:0]   in_mag;
	logic [adn_pkg::PROD_W-1:0]  sy_x128;
	logic                        step_ge;
	logic [adn_pkg::ABS_W-1:0]   qmag;
	logic [7:0]                  qval;

	// below 128 the signed value is negative
	assign in_neg  = ~sample[7];
	assign in_abs  = in_neg ? (8'd128 - sample) : {1'b0, sample[6:0]};
	assign in_mag  = adn_pkg::MAG_ROM[in_abs];
	assign sy_x128 = {sy_q, 7'd0};
	assign step_ge = rem_q >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
		end else if (cmd.clr) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
		end else if (cmd.wr) begin
			cnt_q <= cnt_q + 1'b1;
			sx_q  <= sx_q + adn_pkg::SX_W'(in_abs);
			sy_q  <= sy_q + adn_pkg::SY_W'(in_mag);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			store_q[cnt_q[adn_pkg::ADDR_W-1:0]] <= {in_neg, in_mag};
		end
		if (cmd.rd) begin
			rd_q <= store_q[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= adn_pkg::PROD_W'(sx_q) * adn_pkg::PROD_W'(rd_q[adn_pkg::MAG_W-1:0]);
			neg_q  <= rd_q[adn_pkg::ENTRY_W-1];
		end
		if (cmd.sat) begin
			zero_q <= (sy_q == '0);
			sat_q  <= (prod_q >= sy_x128);
			rem_q  <= prod_q;
			dv_q   <= {sy_q, 6'd0};
			quo_q  <= '0;
		end else if (cmd.div) begin
			if (step_ge) begin
				rem_q <= rem_q - adn_pkg::PROD_W'(dv_q);
			end
			quo_q <= {quo_q[adn_pkg::QUO_W-2:0], step_ge};
			dv_q  <= dv_q >> 1;
		end
	end

	// positive 128 clips to 127, negative 128 stays
	assign qmag = sat_q ? 8'd128 : {1'b0, quo_q};
	always_comb begin
		if (zero_q) begin
			qval = 8'd0;
		end else if (neg_q) begin
			qval = 8'd0 - qmag;
		end else if (sat_q) begin
			qval = 8'd127;
		end else begin
			qval = qmag;
		end
	end

	assign sample_out = qval ^ 8'h80;
	assign status.cnt = cnt_q;

endmodule

`default_nettype wire

// File: hw/rtl/adn_ctrl.sv
`default_nettype none

module adn_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            in_last,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic                 out_last,
	input  wire adn_pkg::status_t status,
	output adn_pkg::cmd_t        cmd
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_READ,
		ST_MUL,
		ST_SAT,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                          state_q;
	logic [adn_pkg::ADDR_W-1:0]      idx_q;
	logic [adn_pkg::DIV_CNT_W-1:0]   div_cnt_q;
	logic                            accept;
	logic                            burst;
	logic                            final_word;

	assign in_ready   = (state_q == ST_LOAD);
	assign out_valid  = (state_q == ST_OUT);
	assign accept     = in_valid && in_ready;
	assign burst      = in_last || (status.cnt == adn_pkg::CNT_W'(adn_pkg::BLOCK_DEPTH - 1));
	assign final_word = ({1'b0, idx_q} + 1'b1) == status.cnt;
	assign out_last   = final_word;

	always_comb begin
		cmd         = '0;
		cmd.rd_addr = idx_q;
		cmd.wr      = accept;
		cmd.rd      = (state_q == ST_READ);
		cmd.mul     = (state_q == ST_MUL);
		cmd.sat     = (state_q == ST_SAT);
		cmd.div     = (state_q == ST_DIV);
		cmd.clr     = (state_q == ST_OUT) && out_ready && final_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			idx_q     <= '0;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					idx_q <= '0;
					if (accept && burst) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_SAT;
				ST_SAT: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == adn_pkg::DIV_CNT_W'(adn_pkg::QUO_W - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold the word until taken, then fetch the next one
					if (out_ready) begin
						if (final_word) begin
							state_q <= ST_LOAD;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/atan_distortion_normalizer_core.sv
// Channel   Dir  tdata (low bit up)   tlast           tuser
// s_axis    in   [7:0] sample         last            -
// m_axis    out  [7:0] sample_out     last_out        -
//
// Loading accepts one word per cycle while s_tready is high.
// A burst starts after the word flagged last or the 64th word; each output word then goes
// through a store read, 14x15 multiply, saturation compare, 7 restoring divide steps and
// hand-off, and waits while m_tready stays low. Input is held off during the burst.
// Reset clears the fill count and both sums; the sample store needs no clearing.
`default_nettype none

module atan_distortion_normalizer_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] sample
	input  wire logic       s_tlast,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] sample_out
	output logic            m_tlast
);

	adn_pkg::cmd_t    cmd;
	adn_pkg::status_t status;

	adn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_last  (m_tlast),
		.status    (status),
		.cmd       (cmd)
	);

	adn_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.sample     (s_tdata),
		.sample_out (m_tdata)
	);

endmodule

`default_nettype wire

// File: hw/rtl/adn_checker.sv
`default_nettype none

module adn_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       s_tlast,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken during a burst");

	a_burst_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("no burst after the last input word");

	a_burst_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("loading did not resume after the burst");

endmodule

bind atan_distortion_normalizer_core adn_checker u_adn_checker (.*);

`default_nettype wire

// File: verif/atan_distortion_normalizer_core_test.sv
`default_nettype none

module atan_distortion_normalizer_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_WORDS = 105;
	localparam int DRAIN_CYCLES = 40;
	localparam int SCRIPT_ROWS  = 25;

	typedef struct packed {
		logic [7:0] pcm;
		logic       tail;
	} pcm_word_t;

	typedef struct packed {
		logic [7:0] pcm;
		logic       tail;
		logic       known;
		logic [7:0] want;
	} script_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'd128;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;

	// typed-in result for single-word blocks, travels alongside the input word
	logic       row_known = 1'b0;
	logic [7:0] row_want = 8'd0;

	// signed curve values indexed by the raw PCM code
	int        curve_tbl [0:255];
	int        held_y [0:adn_pkg::BLOCK_DEPTH-1];
	int        held_n = 0;
	longint    sum_in = 0;
	longint    sum_curve = 0;
	pcm_word_t pending_out [$];

	int errors = 0;
	int words_in = 0;
	int words_out = 0;
	int bursts = 0;
	int idle_cycles = 0;

	// single-word blocks with typed results first, then multi-word blocks
	script_row_t script [SCRIPT_ROWS] = '{
		'{8'd128, 1'b1, 1'b1, 8'd128},
		'{8'd255, 1'b1, 1'b1, 8'd255},
		'{8'd0,   1'b1, 1'b1, 8'd0},
		'{8'd1,   1'b1, 1'b1, 8'd1},
		'{8'd127, 1'b1, 1'b1, 8'd127},
		'{8'd129, 1'b1, 1'b1, 8'd129},
		'{8'd128, 1'b0, 1'b0, 8'd0},
		'{8'd128, 1'b0, 1'b0, 8'd0},
		'{8'd128, 1'b1, 1'b0, 8'd0},
		'{8'd0,   1'b0, 1'b0, 8'd0},
		'{8'd255, 1'b0, 1'b0, 8'd0},
		'{8'd128, 1'b0, 1'b0, 8'd0},
		'{8'd200, 1'b0, 1'b0, 8'd0},
		'{8'd50,  1'b1, 1'b0, 8'd0},
		'{8'd0,   1'b0, 1'b0, 8'd0},
		'{8'd0,   1'b0, 1'b0, 8'd0},
		'{8'd255, 1'b1, 1'b0, 8'd0},
		'{8'd129, 1'b0, 1'b0, 8'd0},
		'{8'd127, 1'b0, 1'b0, 8'd0},
		'{8'd129, 1'b1, 1'b0, 8'd0},
		'{8'd255, 1'b0, 1'b0, 8'd0},
		'{8'd255, 1'b0, 1'b0, 8'd0},
		'{8'd0,   1'b1, 1'b0, 8'd0},
		'{8'd170, 1'b0, 1'b0, 8'd0},
		'{8'd85,  1'b1, 1'b0, 8'd0}
	};

	atan_distortion_normalizer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// pi/2 - atan(1/a) in Q32 by the alternating series, rounded to FRAC_BITS
	function automatic int curve_magnitude(input int unsigned m);
		longint unsigned a;
		longint unsigned a2;
		longint unsigned pw;
		longint unsigned acc;
		longint unsigned ang;
		int unsigned     k;
		bit              minus;
		if (m == 0) begin
			return 0;
		end
		a     = (adn_pkg::DRIVE_DEN << 32) / (adn_pkg::DRIVE_NUM * longint'(m));
		a2    = (a * a) >> 32;
		acc   = a;
		pw    = a;
		minus = 1'b1;
		for (k = 3; pw != 0 && k < 400; k += 2) begin
			pw = (pw * a2) >> 32;
			if (minus) begin
				acc = acc - pw / k;
			end else begin
				acc = acc + pw / k;
			end
			minus = !minus;
		end
		ang = adn_pkg::HALF_PI_Q32 - acc;
		return int'((ang + (64'd1 << (31 - adn_pkg::FRAC_BITS))) >> (32 - adn_pkg::FRAC_BITS));
	endfunction

	// store one word; at the end of a block queue the whole normalized burst
	function automatic void absorb_sample(input logic [7:0] pcm, input logic tail);
		int     x;
		int     y;
		int     mag;
		int     q;
		longint quo;
		x = int'(pcm) - 128;
		y = curve_tbl[pcm];
		held_y[held_n] = y;
		held_n++;
		sum_in    += (x < 0) ? -x : x;
		sum_curve += (y < 0) ? -y : y;
		if (!tail && held_n < adn_pkg::BLOCK_DEPTH) begin
			return;
		end
		for (int i = 0; i < held_n; i++) begin
			q = 0;
			if (sum_curve != 0) begin
				mag = (held_y[i] < 0) ? -held_y[i] : held_y[i];
				quo = (sum_in * longint'(mag)) / sum_curve;
				if (quo > 128) begin
					quo = 128;
				end
				q = (held_y[i] < 0) ? -int'(quo) : int'(quo);
				if (q > 127) begin
					q = 127;
				end
			end
			pending_out.push_back('{pcm: 8'(q + 128), tail: (i == held_n - 1)});
		end
		bursts++;
		held_n    = 0;
		sum_in    = 0;
		sum_curve = 0;
	endfunction

	function automatic logic [7:0] pick_pcm();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd128 + 8'($urandom_range(0, 2)) - 8'd1;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_word(input logic [7:0] pcm, input logic tail, input logic known,
			input logic [7:0] want, input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tdata   <= pcm;
		s_tlast   <= tail;
		row_known <= known;
		row_want  <= want;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// input and output monitor, predictor hook and watchdog
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			words_out++;
			if (pending_out.size() == 0) begin
				errors++;
				$display("%0t: unexpected word sample_out=%0d last_out=%0b",
					$time, m_tdata, m_tlast);
			end else begin
				if (m_tdata !== pending_out[0].pcm) begin
					errors++;
					$display("%0t: sample_out expected %0d got %0d",
						$time, pending_out[0].pcm, m_tdata);
				end
				if (m_tlast !== pending_out[0].tail) begin
					errors++;
					$display("%0t: last_out expected %0b got %0b",
						$time, pending_out[0].tail, m_tlast);
				end
				void'(pending_out.pop_front());
			end
		end
		if (s_tvalid && s_tready) begin
			words_in++;
			absorb_sample(s_tdata, s_tlast);
			// typed-in rows are single-word blocks: replace the predicted word
			if (row_known) begin
				pending_out[pending_out.size() - 1] = '{pcm: row_want, tail: 1'b1};
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles == STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// sink: draw a stall before every word, with quiet stretches
	initial begin : sink
		int  stall;
		bit  quiet;
		quiet = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0) begin
				quiet = !quiet;
			end
			stall = quiet ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	initial begin : source
		int         sent;
		int         span;
		int         gap;
		bit         quiet;
		bit         paused;
		logic       tail;
		sent   = 0;
		quiet  = 1'b0;
		paused = 1'b0;
		for (int c = 0; c < 256; c++) begin
			curve_tbl[c] = (c < 128) ? -curve_magnitude(128 - c) : curve_magnitude(c - 128);
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[r]) begin
			send_word(script[r].pcm, script[r].tail, script[r].known, script[r].want,
				$urandom_range(0, 19));
		end

		// random blocks: one full store first, then mostly short ones
		while (sent < RANDOM_WORDS) begin
			if (bursts == SCRIPT_ROWS && sent == 0) begin
				span = adn_pkg::BLOCK_DEPTH;
			end else if ($urandom_range(0, 9) == 0) begin
				span = $urandom_range(9, 24);
			end else begin
				span = $urandom_range(1, 8);
			end
			if (sent == 0) begin
				span = adn_pkg::BLOCK_DEPTH;
			end
			for (int i = 0; i < span; i++) begin
				if ($urandom_range(0, 11) == 0) begin
					quiet = !quiet;
				end
				gap = quiet ? 0 : $urandom_range(0, 19);
				// a full store ends the block whatever the flag says
				tail = (i == span - 1) ? ((span == adn_pkg::BLOCK_DEPTH)
					? 1'($urandom_range(0, 1)) : 1'b1) : 1'b0;
				send_word(pick_pcm(), tail, 1'b0, 8'd0, gap);
				sent++;
			end
			// hold off until the burst just triggered has fully drained
			if (!paused && sent > RANDOM_WORDS / 2) begin
				paused = 1'b1;
				s_tvalid <= 1'b0;
				do @(negedge clk); while (pending_out.size() != 0);
			end
		end
		s_tvalid <= 1'b0;

		while (pending_out.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d samples in %0d blocks (one full store, single-word extremes,",
			words_in, bursts);
		$display("silent and saturating blocks); checked %0d output words.", words_out);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: atan_distortion_normalizer_core.f
hw/rtl/adn_pkg.sv
hw/rtl/adn_datapath.sv
hw/rtl/adn_ctrl.sv
hw/rtl/atan_distortion_normalizer_core.sv
hw/rtl/adn_checker.sv
verif/atan_distortion_normalizer_core_test.sv
